// ===== hdl/ddp_pkg.sv =====
// Shared types, widths, register codes and reset values for the disparity-to-depth pipeline.
package ddp_pkg;

    localparam int DISP_W             = 16;
    localparam int FB_W               = 32;
    localparam int DEPTH_W            = 24;
    localparam int MM_W               = 16;
    localparam int FRAC_BITS          = 8;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 32;
    localparam int DIV_BITS_PER_STAGE = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_BASELINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_LO        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_HI        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MAX      = 3'd4;

    localparam logic [FB_W-1:0]   RST_FOCAL_BASELINE = 32'd12800000;
    localparam logic [DISP_W-1:0] RST_DISP_LO        = 16'd0;
    localparam logic [DISP_W-1:0] RST_DISP_HI        = 16'd16384;
    localparam logic [MM_W-1:0]   RST_DEPTH_MIN      = 16'd1500;
    localparam logic [MM_W-1:0]   RST_DEPTH_MAX      = 16'd15000;

    typedef struct packed {
        logic [DISP_W-1:0] disparity;
        logic              end_of_line;
    } disp_in_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_fine;
        logic [MM_W-1:0]    depth_mm;
        logic               in_range;
        logic               end_of_line_out;
    } depth_out_t;

    typedef struct packed {
        logic [FB_W-1:0]   focal_baseline_mm;
        logic [DISP_W-1:0] disp_lo;
        logic [DISP_W-1:0] disp_hi;
        logic [MM_W-1:0]   depth_min_mm;
        logic [MM_W-1:0]   depth_max_mm;
    } cfg_t;

    // One item in flight through the divider stages.
    typedef struct packed {
        logic [DISP_W-1:0]  rem;
        logic [DEPTH_W-1:0] pending;
        logic [DEPTH_W-1:0] quot;
        logic [DISP_W-1:0]  divisor;
        logic               ovf;
        logic               in_range;
        logic               eol;
    } div_t;

endpackage

// ===== hdl/ddp_cfg.sv =====
// Configuration register file for the disparity-to-depth pipeline.
module ddp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ddp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ddp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ddp_pkg::cfg_t                    cfg
);
    import ddp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_baseline_mm <= RST_FOCAL_BASELINE;
            cfg_reg.disp_lo           <= RST_DISP_LO;
            cfg_reg.disp_hi           <= RST_DISP_HI;
            cfg_reg.depth_min_mm      <= RST_DEPTH_MIN;
            cfg_reg.depth_max_mm      <= RST_DEPTH_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FOCAL_BASELINE: cfg_reg.focal_baseline_mm <= cfg_data;
                REG_DISP_LO:        cfg_reg.disp_lo           <= cfg_data[DISP_W-1:0];
                REG_DISP_HI:        cfg_reg.disp_hi           <= cfg_data[DISP_W-1:0];
                REG_DEPTH_MIN:      cfg_reg.depth_min_mm      <= cfg_data[MM_W-1:0];
                REG_DEPTH_MAX:      cfg_reg.depth_max_mm      <= cfg_data[MM_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== hdl/ddp_div_stage.sv =====
// One pipelined stage of the restoring divider, producing BITS quotient bits per item.
module ddp_div_stage #(
    parameter int BITS = ddp_pkg::DIV_BITS_PER_STAGE
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ddp_pkg::div_t in_item,
    output logic          out_valid,
    input  logic          out_stall,
    output ddp_pkg::div_t out_item
);
    import ddp_pkg::*;

    logic valid_reg;
    logic valid_next;
    div_t item_reg;
    div_t item_next;
    logic advance;

    // Unless the item overflowed, the partial remainder stays below the divisor, so each trial difference fits 16 bits.
    always_comb
    begin
        logic [DISP_W:0] trial;
        item_next = in_item;
        for (int i = 0; i < BITS; i++)
        begin
            trial = {item_next.rem, item_next.pending[DEPTH_W-1]};
            item_next.pending = {item_next.pending[DEPTH_W-2:0], 1'b0};
            if (trial >= {1'b0, item_next.divisor})
            begin
                item_next.rem  = DISP_W'(trial - {1'b0, item_next.divisor});
                item_next.quot = {item_next.quot[DEPTH_W-2:0], 1'b1};
            end
            else
            begin
                item_next.rem  = trial[DISP_W-1:0];
                item_next.quot = {item_next.quot[DEPTH_W-2:0], 1'b0};
            end
        end
    end

    assign advance    = !valid_reg || !out_stall;
    assign in_stall   = !advance;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hdl/disparity_to_depth_pixel.sv =====
// Pipeline: an entry register, the divider stages and an output register, in that order.
// Throughput: one item per cycle; the restoring divider retires BITS_PER_STAGE
// quotient bits per pipeline stage, and a stall only holds stages that are full.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and loads
// the configuration registers with their default values.
module disparity_to_depth_pixel #(
    parameter int BITS_PER_STAGE = ddp_pkg::DIV_BITS_PER_STAGE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ddp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           disp_valid,
    output logic                           disp_stall,
    input  ddp_pkg::disp_in_t              disp_item,
    output logic                           depth_valid,
    input  logic                           depth_stall,
    output ddp_pkg::depth_out_t            depth_item
);
    import ddp_pkg::*;

    localparam int NUM_DIV_STAGES = DEPTH_W / BITS_PER_STAGE;

    cfg_t       cfg;
    logic       div_valid [0:NUM_DIV_STAGES];
    logic       div_stall [0:NUM_DIV_STAGES];
    div_t       div_item  [0:NUM_DIV_STAGES];

    logic       s0_valid_reg;
    logic       s0_valid_next;
    div_t       s0_item_reg;
    div_t       s0_item_next;
    logic       s0_advance;

    logic       out_valid_reg;
    logic       out_valid_next;
    depth_out_t out_item_reg;
    depth_out_t out_item_next;
    logic       out_advance;

    ddp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Entry stage: range check, overflow test and divider setup.
    // The quotient needs more than 24 bits exactly when the upper half of the
    // focal-baseline word is not below the divisor; such a depth clamps to the maximum.
    always_comb
    begin
        s0_item_next.in_range = (disp_item.disparity > cfg.disp_lo) &&
                                (disp_item.disparity < cfg.disp_hi);
        s0_item_next.ovf      = cfg.focal_baseline_mm[FB_W-1:DISP_W] >= disp_item.disparity;
        s0_item_next.rem      = cfg.focal_baseline_mm[FB_W-1:DISP_W];
        s0_item_next.pending  = {cfg.focal_baseline_mm[DISP_W-1:0], {FRAC_BITS{1'b0}}};
        s0_item_next.quot     = '0;
        s0_item_next.divisor  = disp_item.disparity;
        s0_item_next.eol      = disp_item.end_of_line;
    end

    assign s0_advance    = !s0_valid_reg || !div_stall[0];
    assign disp_stall    = !s0_advance;
    assign s0_valid_next = s0_advance ? disp_valid : s0_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_advance && disp_valid)
        begin
            s0_item_reg <= s0_item_next;
        end
    end

    assign div_valid[0] = s0_valid_reg;
    assign div_item[0]  = s0_item_reg;

    for (genvar k = 0; k < NUM_DIV_STAGES; k++)
    begin : g_div
        ddp_div_stage #(
            .BITS (BITS_PER_STAGE)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_stall  (div_stall[k]),
            .in_item   (div_item[k]),
            .out_valid (div_valid[k+1]),
            .out_stall (div_stall[k+1]),
            .out_item  (div_item[k+1])
        );
    end

    // Output stage: the maximum is tested first, so an inverted clamp window favors the maximum.
    // An overflowed quotient is above every maximum and never reaches the minimum test.
    always_comb
    begin
        logic [DEPTH_W-1:0] max_fine;
        logic [DEPTH_W-1:0] min_fine;
        logic [DEPTH_W-1:0] depth;
        max_fine = {cfg.depth_max_mm, {FRAC_BITS{1'b0}}};
        min_fine = {cfg.depth_min_mm, {FRAC_BITS{1'b0}}};
        if (!div_item[NUM_DIV_STAGES].in_range)
        begin
            depth = max_fine;
        end
        else if (div_item[NUM_DIV_STAGES].ovf || div_item[NUM_DIV_STAGES].quot > max_fine)
        begin
            depth = max_fine;
        end
        else if (div_item[NUM_DIV_STAGES].quot < min_fine)
        begin
            depth = min_fine;
        end
        else
        begin
            depth = div_item[NUM_DIV_STAGES].quot;
        end
        out_item_next.depth_fine      = depth;
        out_item_next.depth_mm        = depth[DEPTH_W-1:FRAC_BITS];
        out_item_next.in_range        = div_item[NUM_DIV_STAGES].in_range;
        out_item_next.end_of_line_out = div_item[NUM_DIV_STAGES].eol;
    end

    assign out_advance               = !out_valid_reg || !depth_stall;
    assign div_stall[NUM_DIV_STAGES] = !out_advance;
    assign out_valid_next            = out_advance ? div_valid[NUM_DIV_STAGES] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && div_valid[NUM_DIV_STAGES])
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign depth_valid = out_valid_reg;
    assign depth_item  = out_item_reg;

endmodule

// ===== hdl/ddp_checker.sv =====
// Port-level checks for the disparity-to-depth pipeline, bound to the top level.
module ddp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           disp_stall,
    input logic                           depth_valid,
    input logic                           depth_stall,
    input ddp_pkg::depth_out_t            depth_item
);
    import ddp_pkg::*;

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        depth_valid && depth_stall |=> depth_valid && $stable(depth_item))
        else $error("result changed while stalled");

    // The whole-millimetre depth is always the floored fine depth.
    a_mm_floor: assert property (@(posedge clk) disable iff (!rst_n)
        depth_valid |-> depth_item.depth_mm == depth_item.depth_fine[DEPTH_W-1:FRAC_BITS])
        else $error("depth_mm does not match depth_fine");

    // An out-of-range pixel reports the maximum depth, which has no fraction bits.
    a_invalid_whole: assert property (@(posedge clk) disable iff (!rst_n)
        depth_valid && !depth_item.in_range |-> depth_item.depth_fine[FRAC_BITS-1:0] == '0)
        else $error("out-of-range pixel carries a fractional depth");

    // The input side only backs up when a finished result is held at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        disp_stall |-> depth_valid && depth_stall)
        else $error("input stalled without a stalled output");

endmodule

bind disparity_to_depth_pixel ddp_checker u_ddp_checker (.*);
